[hw/rtl/pqps_pkg.sv]
// pqps_pkg: shared types, codes and reset values for the periodic query poll scheduler
// used by pqps_cfg and periodic_query_poll_scheduler_top; no dependencies
package pqps_pkg;

	localparam int unsigned NUM_QUERY_TYPES = 5;
	localparam int unsigned QTYPE_W         = 3;
	localparam int unsigned SEQ_W           = 16;
	localparam int unsigned TIME_W          = 32;
	localparam int unsigned IVL_W           = 16;
	localparam int unsigned BACKLOG_W       = 8;
	localparam int unsigned CNT_W           = 32;

	// apb register map
	localparam int unsigned CFG_ADDR_W = 5;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PING_IVL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_IVL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_IVL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POD_IVL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_IVL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_LIM = 3'd6;

	// reset values
	localparam logic [IVL_W-1:0]     RST_PING_IVL    = 16'd1000;
	localparam logic [IVL_W-1:0]     RST_POS_IVL     = 16'd40;
	localparam logic [IVL_W-1:0]     RST_STATUS_IVL  = 16'd1000;
	localparam logic [IVL_W-1:0]     RST_POD_IVL     = 16'd25;
	localparam logic [IVL_W-1:0]     RST_MIDI_IVL    = 16'd50;
	localparam logic [IVL_W-1:0]     RST_TIMEOUT     = 16'd400;
	localparam logic [BACKLOG_W-1:0] RST_BACKLOG_LIM = 8'd8;

	// query types, same encoding as response types
	localparam logic [QTYPE_W-1:0] QT_PING   = 3'd0;
	localparam logic [QTYPE_W-1:0] QT_POS    = 3'd1;
	localparam logic [QTYPE_W-1:0] QT_STATUS = 3'd2;
	localparam logic [QTYPE_W-1:0] QT_POD    = 3'd3;
	localparam logic [QTYPE_W-1:0] QT_MIDI   = 3'd4;

	// input word kinds
	typedef enum logic [1:0] {
		KIND_TICK      = 2'd0,
		KIND_RESPONSE  = 2'd1,
		KIND_OTHER_TX  = 2'd2,
		KIND_LINK_DOWN = 2'd3
	} kind_t;

	// send outcomes
	localparam logic [1:0] OUT_REFUSED    = 2'd0;
	localparam logic [1:0] OUT_WRITE_FAIL = 2'd1;

	// result actions
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_SENT   = 2'd1;
	localparam logic [1:0] ACT_FAILED = 2'd2;

	// configuration seen by the scheduler
	typedef struct packed {
		logic [NUM_QUERY_TYPES-1:0][IVL_W-1:0] interval;
		logic [IVL_W-1:0]                      timeout;
		logic [BACKLOG_W-1:0]                  backlog_limit;
	} cfg_t;

endpackage

[hw/rtl/periodic_query_poll_scheduler_top.sv]
// periodic_query_poll_scheduler_top: query scheduler datapath with input and result registers
// depends on pqps_pkg and pqps_cfg
// an accepted word enters the input register, then the result register once the result stream is free
// throughput: one word per cycle unless the result stream stalls; single decision stage between the two registers
// reset: asynchronous, clears pending query, sequence counter, issue times and totals,
// and loads the configuration registers with their default values
module periodic_query_poll_scheduler_top
	import pqps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_ms[31:0], tx_backlog[39:32], send_outcome[41:40], midi_available[42],
	// resp_type[45:43], resp_sequence[61:46], zero fill [63:62]
	input  logic [63:0]           s_tdata,
	// kind[1:0]
	input  logic [1:0]            s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// query_type[2:0], given_seq[18:3], timed_out[19], query_busy[20],
	// timeout_total[52:21], stale_total[84:53], zero fill [87:85]
	output logic [87:0]           m_tdata,
	// action[1:0]
	output logic [1:0]            m_tuser
);

	cfg_t cfg;

	pqps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic                 v_s1;
	kind_t                kind_s1;
	logic [TIME_W-1:0]    now_s1;
	logic [BACKLOG_W-1:0] backlog_s1;
	logic [1:0]           outcome_s1;
	logic                 midi_s1;
	logic [QTYPE_W-1:0]   rtype_s1;
	logic [SEQ_W-1:0]     rseq_s1;

	// scheduler state
	logic                                   busy_q;
	logic [QTYPE_W-1:0]                     busy_type_q;
	logic [SEQ_W-1:0]                       busy_seq_q;
	logic [TIME_W-1:0]                      busy_since_q;
	logic [NUM_QUERY_TYPES-1:0][TIME_W-1:0] last_issue_q;
	logic [SEQ_W-1:0]                       next_seq_q;
	logic [CNT_W-1:0]                       timeout_cnt_q;
	logic [CNT_W-1:0]                       stale_cnt_q;

	// result register
	logic             m_tvalid_q;
	logic [1:0]       action_q;
	logic [QTYPE_W-1:0] qtype_q;
	logic [SEQ_W-1:0] aseq_q;
	logic             timed_out_q;
	logic             qbusy_q;
	logic [CNT_W-1:0] timeout_tot_q;
	logic [CNT_W-1:0] stale_tot_q;

	logic load;
	logic in_acc;

	assign load     = v_s1 & (~m_tvalid_q | m_tready);
	assign s_tready = ~v_s1 | load;
	assign in_acc   = s_tvalid & s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1    <= kind_t'(s_tuser);
			now_s1     <= s_tdata[31:0];
			backlog_s1 <= s_tdata[39:32];
			outcome_s1 <= s_tdata[41:40];
			midi_s1    <= s_tdata[42];
			rtype_s1   <= s_tdata[45:43];
			rseq_s1    <= s_tdata[61:46];
		end
	end

	// decision logic
	logic                       is_tick;
	logic                       is_resp;
	logic                       waiting;
	logic                       expire;
	logic [NUM_QUERY_TYPES-1:0] due;
	logic [QTYPE_W-1:0]         pick;
	logic                       attempt;
	logic                       take_seq;
	logic                       sent;
	logic                       type_match;
	logic                       resp_clear;
	logic                       stale_inc;
	logic                       busy_nxt;
	logic [TIME_W-1:0]          busy_age;

	assign is_tick  = (kind_s1 == KIND_TICK);
	assign is_resp  = (kind_s1 == KIND_RESPONSE);
	assign busy_age = now_s1 - busy_since_q;
	assign waiting  = busy_q & (busy_age < TIME_W'(cfg.timeout));
	assign expire   = is_tick & busy_q & ~waiting;

	// due flags per query type, midi only when the peer offers it
	always_comb begin
		for (int i = 0; i < NUM_QUERY_TYPES; i++) begin
			due[i] = (now_s1 - last_issue_q[i]) >= TIME_W'(cfg.interval[i]);
		end
		due[QT_MIDI] = due[QT_MIDI] & midi_s1;
	end

	// fixed priority, lowest type first
	always_comb begin
		pick = QT_PING;
		for (int i = NUM_QUERY_TYPES - 1; i >= 0; i--) begin
			if (due[i]) begin
				pick = QTYPE_W'(i);
			end
		end
	end

	assign attempt  = is_tick & ~waiting & (backlog_s1 <= cfg.backlog_limit) & (|due);
	assign take_seq = (attempt | (kind_s1 == KIND_OTHER_TX)) & (outcome_s1 != OUT_REFUSED);
	assign sent     = attempt & (outcome_s1 != OUT_REFUSED) & (outcome_s1 != OUT_WRITE_FAIL);

	assign type_match = is_resp & busy_q & (rtype_s1 < QTYPE_W'(NUM_QUERY_TYPES))
		& (rtype_s1 == busy_type_q);
	assign resp_clear = type_match & (rseq_s1 == busy_seq_q);
	assign stale_inc  = type_match & (rseq_s1 != busy_seq_q);

	// pending flag after this word
	always_comb begin
		busy_nxt = busy_q;
		case (kind_s1)
			KIND_TICK:      busy_nxt = sent | (busy_q & ~expire);
			KIND_RESPONSE:  busy_nxt = busy_q & ~resp_clear;
			KIND_OTHER_TX:  busy_nxt = busy_q;
			KIND_LINK_DOWN: busy_nxt = 1'b0;
			default:        busy_nxt = busy_q;
		endcase
	end

	// state update as the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			busy_type_q   <= QT_PING;
			busy_seq_q    <= '0;
			busy_since_q  <= '0;
			last_issue_q  <= '0;
			next_seq_q    <= '0;
			timeout_cnt_q <= '0;
			stale_cnt_q   <= '0;
		end else if (load) begin
			busy_q        <= busy_nxt;
			timeout_cnt_q <= timeout_cnt_q + CNT_W'(expire);
			stale_cnt_q   <= stale_cnt_q + CNT_W'(stale_inc);
			if (take_seq) begin
				next_seq_q <= next_seq_q + SEQ_W'(1);
			end
			if (sent) begin
				busy_type_q        <= pick;
				busy_seq_q         <= next_seq_q;
				busy_since_q       <= now_s1;
				last_issue_q[pick] <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			action_q      <= attempt ? (sent ? ACT_SENT : ACT_FAILED) : ACT_NONE;
			qtype_q       <= attempt ? pick : QT_PING;
			aseq_q        <= (attempt & take_seq) ? next_seq_q : '0;
			timed_out_q   <= expire;
			qbusy_q       <= busy_nxt;
			timeout_tot_q <= timeout_cnt_q + CNT_W'(expire);
			stale_tot_q   <= stale_cnt_q + CNT_W'(stale_inc);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = action_q;
	assign m_tdata  = {3'b000, stale_tot_q, timeout_tot_q, qbusy_q, timed_out_q, aseq_q, qtype_q};

	// checks

	// a sent query always leaves a query pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ACT_SENT) |-> qbusy_q)
		else $error("sent query not pending");

	// nothing issued reports neither type nor sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ACT_NONE) |-> (qtype_q == QT_PING && aseq_q == '0))
		else $error("idle result carries query fields");

	// expiry counter advances by exactly the expiry flag of the word that moved on
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (timeout_cnt_q == $past(timeout_cnt_q) + CNT_W'($past(expire))))
		else $error("timeout counter out of step");

	// a query only becomes pending from a tick
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(load && kind_s1 == KIND_TICK))
		else $error("pending query raised outside a tick");

	// the pending type is always a real query type
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (busy_type_q < QTYPE_W'(NUM_QUERY_TYPES)))
		else $error("pending type out of range");

endmodule

[hw/rtl/pqps_cfg.sv]
// pqps_cfg: apb register file holding intervals, timeout and backlog limit
// depends on pqps_pkg
module pqps_cfg
	import pqps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t                 cfg_q;
	logic [CFG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval[QT_PING]   <= RST_PING_IVL;
			cfg_q.interval[QT_POS]    <= RST_POS_IVL;
			cfg_q.interval[QT_STATUS] <= RST_STATUS_IVL;
			cfg_q.interval[QT_POD]    <= RST_POD_IVL;
			cfg_q.interval[QT_MIDI]   <= RST_MIDI_IVL;
			cfg_q.timeout             <= RST_TIMEOUT;
			cfg_q.backlog_limit       <= RST_BACKLOG_LIM;
		end else if (wr_en) begin
			case (idx)
				REG_PING_IVL:    cfg_q.interval[QT_PING]   <= pwdata[IVL_W-1:0];
				REG_POS_IVL:     cfg_q.interval[QT_POS]    <= pwdata[IVL_W-1:0];
				REG_STATUS_IVL:  cfg_q.interval[QT_STATUS] <= pwdata[IVL_W-1:0];
				REG_POD_IVL:     cfg_q.interval[QT_POD]    <= pwdata[IVL_W-1:0];
				REG_MIDI_IVL:    cfg_q.interval[QT_MIDI]   <= pwdata[IVL_W-1:0];
				REG_TIMEOUT:     cfg_q.timeout             <= pwdata[IVL_W-1:0];
				REG_BACKLOG_LIM: cfg_q.backlog_limit       <= pwdata[BACKLOG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_PING_IVL:    prdata = CFG_DATA_W'(cfg_q.interval[QT_PING]);
			REG_POS_IVL:     prdata = CFG_DATA_W'(cfg_q.interval[QT_POS]);
			REG_STATUS_IVL:  prdata = CFG_DATA_W'(cfg_q.interval[QT_STATUS]);
			REG_POD_IVL:     prdata = CFG_DATA_W'(cfg_q.interval[QT_POD]);
			REG_MIDI_IVL:    prdata = CFG_DATA_W'(cfg_q.interval[QT_MIDI]);
			REG_TIMEOUT:     prdata = CFG_DATA_W'(cfg_q.timeout);
			REG_BACKLOG_LIM: prdata = CFG_DATA_W'(cfg_q.backlog_limit);
			default:         prdata = '0;
		endcase
	end

endmodule

[sim/tb_periodic_query_poll_scheduler_top.sv]
// tb_periodic_query_poll_scheduler_top: self-checking bench for the query poll scheduler,
// a directed table then random phases over several register settings, checked word by word
// depends on pqps_pkg and periodic_query_poll_scheduler_top
module tb_periodic_query_poll_scheduler_top;
	import pqps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// outcome and response codes not named in the package
	localparam logic [1:0] OUT_SENT     = 2'd2;
	localparam logic [1:0] OUT_UNDEF    = 2'd3;
	localparam logic [2:0] RT_OTHER     = 3'd5;
	localparam logic [2:0] RT_SPARE     = 3'd6;
	localparam logic [2:0] RT_RESERVED  = 3'd7;
	localparam int         STALL_LIMIT  = 4000;
	localparam int         DRAIN_CYCLES = 4;
	localparam int         DIR_ROWS     = 23;
	localparam int         ZERO_CFG_ROW = 20;

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  now_ms;
		logic [7:0]   tx_backlog;
		logic [1:0]   send_outcome;
		logic         midi_available;
		logic [2:0]   resp_type;
		logic [15:0]  resp_sequence;
	} poll_in_t;

	typedef struct packed {
		logic [1:0]   action;
		logic [2:0]   query_type;
		logic [15:0]  given_seq;
		logic         timed_out;
		logic         query_busy;
		logic [31:0]  timeout_total;
		logic [31:0]  stale_total;
	} poll_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [87:0]           m_tdata;
	logic [1:0]            m_tuser;

	// scheduler model: configuration and state
	logic [15:0]  cfg_ivl [NUM_QUERY_TYPES];
	logic [15:0]  cfg_timeout;
	logic [7:0]   cfg_backlog_lim;
	logic         pend_busy;
	logic [2:0]   pend_type;
	logic [15:0]  pend_seq;
	logic [31:0]  pend_since;
	logic [31:0]  last_sent [NUM_QUERY_TYPES];
	logic [15:0]  seq_next;
	logic [31:0]  n_timeouts;
	logic [31:0]  n_stale;

	poll_res_t    pending_results [$];
	logic [31:0]  clock_ms;
	bit           quiet;
	int           errors;
	int           n_words;
	int           n_sent_seen;
	int           n_expired_seen;
	int           n_settings;
	int           stall;

	periodic_query_poll_scheduler_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// one word of the scheduler: expiry, priority pick, responses, sequence use
	function automatic poll_res_t predict_schedule(input poll_in_t w);
		poll_res_t   r;
		logic        blocked;
		logic        found;
		int unsigned span;
		int unsigned pick;
		logic [31:0] gap;
		r = '0;
		blocked = 1'b0;
		found = 1'b0;
		pick = 0;
		case (w.kind)
			KIND_TICK: begin
				if (pend_busy) begin
					gap = w.now_ms - pend_since;
					if (gap < {16'd0, cfg_timeout}) begin
						blocked = 1'b1;
					end else begin
						pend_busy = 1'b0;
						n_timeouts = n_timeouts + 32'd1;
						r.timed_out = 1'b1;
					end
				end
				if (!blocked && w.tx_backlog <= cfg_backlog_lim) begin
					span = w.midi_available ? NUM_QUERY_TYPES : NUM_QUERY_TYPES - 1;
					for (int t = 0; t < span; t++) begin
						gap = w.now_ms - last_sent[t];
						if (!found && gap >= {16'd0, cfg_ivl[t]}) begin
							found = 1'b1;
							pick = t;
						end
					end
					if (found) begin
						r.query_type = pick[2:0];
						if (w.send_outcome == OUT_REFUSED) begin
							r.action = ACT_FAILED;
						end else if (w.send_outcome == OUT_WRITE_FAIL) begin
							r.given_seq = seq_next;
							seq_next = seq_next + 16'd1;
							r.action = ACT_FAILED;
						end else begin
							r.given_seq = seq_next;
							seq_next = seq_next + 16'd1;
							r.action = ACT_SENT;
							pend_busy = 1'b1;
							pend_type = pick[2:0];
							pend_seq = r.given_seq;
							pend_since = w.now_ms;
							last_sent[pick] = w.now_ms;
						end
					end
				end
			end
			KIND_RESPONSE: begin
				if (pend_busy && w.resp_type < NUM_QUERY_TYPES && w.resp_type == pend_type) begin
					if (w.resp_sequence == pend_seq)
						pend_busy = 1'b0;
					else
						n_stale = n_stale + 32'd1;
				end
			end
			KIND_OTHER_TX: begin
				if (w.send_outcome != OUT_REFUSED)
					seq_next = seq_next + 16'd1;
			end
			default: begin
				pend_busy = 1'b0;
			end
		endcase
		r.query_busy = pend_busy;
		r.timeout_total = n_timeouts;
		r.stale_total = n_stale;
		return r;
	endfunction

	function automatic poll_in_t make_word(kind_t k, logic [31:0] now, logic [7:0] backlog,
			logic [1:0] outcome, logic midi, logic [2:0] rtype, logic [15:0] rseq);
		poll_in_t w;
		w.kind = k;
		w.now_ms = now;
		w.tx_backlog = backlog;
		w.send_outcome = outcome;
		w.midi_available = midi;
		w.resp_type = rtype;
		w.resp_sequence = rseq;
		return w;
	endfunction

	// result readable straight off the opening state: no totals, nothing pending
	function automatic poll_res_t fixed_result(logic [1:0] act, logic [2:0] qt);
		poll_res_t r;
		r = '0;
		r.action = act;
		r.query_type = qt;
		return r;
	endfunction

	// random word: mostly advancing time, responses aimed at the pending query
	function automatic poll_in_t random_word(int unsigned step);
		poll_in_t    w;
		int unsigned roll;
		int unsigned pick;
		if ($urandom_range(0, 99) < 3)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, step);
		w.now_ms = clock_ms;
		if ($urandom_range(0, 99) < 80)
			w.tx_backlog = 8'($urandom_range(0, cfg_backlog_lim));
		else
			w.tx_backlog = 8'($urandom);
		pick = $urandom_range(0, 9);
		case (pick)
			0: w.send_outcome = OUT_REFUSED;
			1: w.send_outcome = OUT_WRITE_FAIL;
			2: w.send_outcome = OUT_UNDEF;
			default: w.send_outcome = OUT_SENT;
		endcase
		w.midi_available = 1'($urandom);
		w.resp_type = 3'($urandom);
		w.resp_sequence = 16'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			w.kind = KIND_TICK;
		end else if (roll < 80) begin
			w.kind = KIND_RESPONSE;
			if (pend_busy && $urandom_range(0, 99) < 70) begin
				w.resp_type = pend_type;
				if ($urandom_range(0, 3) != 0)
					w.resp_sequence = pend_seq;
			end
		end else if (roll < 92) begin
			w.kind = KIND_OTHER_TX;
		end else begin
			w.kind = KIND_LINK_DOWN;
		end
		return w;
	endfunction

	// present one word, hold it until taken, then queue its result
	task automatic send_word(input poll_in_t w, input bit known, input poll_res_t fixed);
		poll_res_t pr;
		while (!quiet && $urandom_range(0, 99) < 31) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= w.kind;
		s_tdata <= {2'b00, w.resp_sequence, w.resp_type, w.midi_available,
			w.send_outcome, w.tx_backlog, w.now_ms};
		do @(posedge clk); while (!s_tready);
		pr = predict_schedule(w);
		pending_results.push_back(known ? fixed : pr);
		n_words++;
	endtask

	// let every expected result out, then the pipeline run dry
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PING_IVL:    cfg_ivl[QT_PING] = val[15:0];
			REG_POS_IVL:     cfg_ivl[QT_POS] = val[15:0];
			REG_STATUS_IVL:  cfg_ivl[QT_STATUS] = val[15:0];
			REG_POD_IVL:     cfg_ivl[QT_POD] = val[15:0];
			REG_MIDI_IVL:    cfg_ivl[QT_MIDI] = val[15:0];
			REG_TIMEOUT:     cfg_timeout = val[15:0];
			REG_BACKLOG_LIM: cfg_backlog_lim = val[7:0];
			default: ;
		endcase
	endtask

	// read every register back against the model
	task automatic cfg_check();
		logic [31:0] got;
		logic [31:0] want;
		logic [31:0] mask;
		for (int i = REG_PING_IVL; i <= REG_BACKLOG_LIM; i++) begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {i[2:0], 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got = prdata;
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			mask = 32'h0000_FFFF;
			case (i[2:0])
				REG_TIMEOUT:     want = {16'd0, cfg_timeout};
				REG_BACKLOG_LIM: begin
					want = {24'd0, cfg_backlog_lim};
					mask = 32'h0000_00FF;
				end
				default:         want = {16'd0, cfg_ivl[i]};
			endcase
			if ((got & mask) !== want) begin
				$display("%0t register %0d: expected %0h actual %0h", $time, i, want, got & mask);
				errors++;
			end
		end
	endtask

	task automatic run_phase(input logic [15:0] iv_ping, input logic [15:0] iv_pos,
			input logic [15:0] iv_status, input logic [15:0] iv_pod, input logic [15:0] iv_midi,
			input logic [15:0] tmo, input logic [7:0] lim, input int unsigned step,
			input int count, input bit no_idle);
		poll_in_t w;
		settle();
		apb_write(REG_PING_IVL, {16'd0, iv_ping});
		apb_write(REG_POS_IVL, {16'd0, iv_pos});
		apb_write(REG_STATUS_IVL, {16'd0, iv_status});
		apb_write(REG_POD_IVL, {16'd0, iv_pod});
		apb_write(REG_MIDI_IVL, {16'd0, iv_midi});
		apb_write(REG_TIMEOUT, {16'd0, tmo});
		apb_write(REG_BACKLOG_LIM, {24'd0, lim});
		cfg_check();
		n_settings++;
		quiet = no_idle;
		for (int n = 0; n < count; n++) begin
			w = random_word(step);
			send_word(w, 1'b0, '0);
		end
		quiet = 1'b0;
	endtask

	// result sink: random back-pressure, always ready in quiet phases
	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(0, 99) >= 31);

	// result checker: field by field against the oldest expectation
	always @(posedge clk) begin
		poll_res_t got;
		poll_res_t want;
		if (m_tvalid && m_tready) begin
			got.action = m_tuser;
			got.query_type = m_tdata[2:0];
			got.given_seq = m_tdata[18:3];
			got.timed_out = m_tdata[19];
			got.query_busy = m_tdata[20];
			got.timeout_total = m_tdata[52:21];
			got.stale_total = m_tdata[84:53];
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result word: action %0h data %0h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t result mismatch", $time);
					$display("  expected: action %0h type %0h seq %0h expired %0b busy %0b timeouts %0h stale %0h",
						want.action, want.query_type, want.given_seq, want.timed_out,
						want.query_busy, want.timeout_total, want.stale_total);
					$display("  actual:   action %0h type %0h seq %0h expired %0b busy %0b timeouts %0h stale %0h",
						got.action, got.query_type, got.given_seq, got.timed_out,
						got.query_busy, got.timeout_total, got.stale_total);
					errors++;
				end
				if (got.action == ACT_SENT)
					n_sent_seen++;
				if (got.timed_out)
					n_expired_seen++;
			end
		end
	end

	// watchdog: cycles without any word moved or register access
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stall <= 0;
		end else if (stall >= STALL_LIMIT) begin
			$display("%0t timeout, %0d results still expected", $time, pending_results.size());
			$display("FAILURE");
			$finish;
		end else begin
			stall <= stall + 1;
		end
	end

	initial begin
		poll_in_t  dir_in [DIR_ROWS];
		bit        dir_known [DIR_ROWS];
		poll_res_t dir_res [DIR_ROWS];

		// model at reset
		cfg_ivl[QT_PING] = RST_PING_IVL;
		cfg_ivl[QT_POS] = RST_POS_IVL;
		cfg_ivl[QT_STATUS] = RST_STATUS_IVL;
		cfg_ivl[QT_POD] = RST_POD_IVL;
		cfg_ivl[QT_MIDI] = RST_MIDI_IVL;
		cfg_timeout = RST_TIMEOUT;
		cfg_backlog_lim = RST_BACKLOG_LIM;
		pend_busy = 1'b0;
		pend_type = '0;
		pend_seq = '0;
		pend_since = '0;
		for (int t = 0; t < NUM_QUERY_TYPES; t++)
			last_sent[t] = '0;
		seq_next = '0;
		n_timeouts = '0;
		n_stale = '0;
		clock_ms = '0;
		quiet = 1'b0;
		errors = 0;
		n_words = 0;
		n_sent_seen = 0;
		n_expired_seen = 0;
		n_settings = 1;
		stall = 0;

		// directed rows; fixed results only where the opening state makes them obvious
		for (int i = 0; i < DIR_ROWS; i++)
			dir_known[i] = 1'b0;
		// nothing due yet at time zero
		dir_in[0]  = make_word(KIND_TICK, 32'd0, 8'd0, OUT_SENT, 1'b1, QT_PING, 16'd0);
		dir_known[0] = 1'b1;
		dir_res[0] = fixed_result(ACT_NONE, QT_PING);
		// backlog one above the limit
		dir_in[1]  = make_word(KIND_TICK, 32'd25, 8'd9, OUT_SENT, 1'b0, QT_PING, 16'd0);
		dir_known[1] = 1'b1;
		dir_res[1] = fixed_result(ACT_NONE, QT_PING);
		// pod due, refused before sequencing
		dir_in[2]  = make_word(KIND_TICK, 32'd25, 8'd8, OUT_REFUSED, 1'b0, QT_PING, 16'd0);
		dir_known[2] = 1'b1;
		dir_res[2] = fixed_result(ACT_FAILED, QT_POD);
		// pod due, write fails after taking sequence zero
		dir_in[3]  = make_word(KIND_TICK, 32'd25, 8'd8, OUT_WRITE_FAIL, 1'b0, QT_PING, 16'd0);
		dir_known[3] = 1'b1;
		dir_res[3] = fixed_result(ACT_FAILED, QT_POD);
		// position sent, then held off while pending
		dir_in[4]  = make_word(KIND_TICK, 32'd40, 8'd8, OUT_SENT, 1'b0, QT_PING, 16'd0);
		dir_in[5]  = make_word(KIND_TICK, 32'd100, 8'd0, OUT_SENT, 1'b1, QT_PING, 16'd0);
		// stale, non-query and matching responses
		dir_in[6]  = make_word(KIND_RESPONSE, 32'd100, 8'd0, OUT_SENT, 1'b0, QT_POS, 16'd0);
		dir_in[7]  = make_word(KIND_RESPONSE, 32'd100, 8'd0, OUT_SENT, 1'b0, RT_OTHER, 16'd1);
		dir_in[8]  = make_word(KIND_RESPONSE, 32'd100, 8'd0, OUT_SENT, 1'b0, QT_POS, 16'd1);
		// other sends with write-fail, refused and undefined outcomes
		dir_in[9]  = make_word(KIND_OTHER_TX, 32'd100, 8'd0, OUT_WRITE_FAIL, 1'b0, QT_PING, 16'd0);
		dir_in[10] = make_word(KIND_OTHER_TX, 32'd100, 8'd0, OUT_REFUSED, 1'b0, QT_PING, 16'd0);
		dir_in[11] = make_word(KIND_OTHER_TX, 32'd100, 8'd0, OUT_UNDEF, 1'b0, QT_PING, 16'd0);
		// undefined outcome counts as sent, then link down clears it
		dir_in[12] = make_word(KIND_TICK, 32'd1000, 8'd0, OUT_UNDEF, 1'b0, QT_PING, 16'd0);
		dir_in[13] = make_word(KIND_LINK_DOWN, 32'd1000, 8'd0, OUT_SENT, 1'b0, QT_PING, 16'd0);
		// position sent, then expires exactly at the timeout
		dir_in[14] = make_word(KIND_TICK, 32'd1000, 8'd0, OUT_SENT, 1'b1, QT_PING, 16'd0);
		dir_in[15] = make_word(KIND_TICK, 32'd1400, 8'd0, OUT_SENT, 1'b1, QT_PING, 16'd0);
		// field extremes and wrapped time
		dir_in[16] = make_word(KIND_TICK, 32'hFFFF_FFFF, 8'hFF, OUT_SENT, 1'b1, RT_RESERVED,
			16'hFFFF);
		dir_in[17] = make_word(KIND_RESPONSE, 32'hFFFF_FFFF, 8'hFF, OUT_UNDEF, 1'b1, RT_RESERVED,
			16'hFFFF);
		dir_in[18] = make_word(KIND_TICK, 32'hFFFF_FFFF, 8'd0, OUT_SENT, 1'b1, QT_PING, 16'd0);
		dir_in[19] = make_word(KIND_RESPONSE, 32'hFFFF_FFFF, 8'd0, OUT_SENT, 1'b1, RT_SPARE,
			16'hFFFF);
		// zero intervals, zero timeout and zero backlog limit from here on
		dir_in[20] = make_word(KIND_TICK, 32'd5, 8'd0, OUT_SENT, 1'b0, QT_PING, 16'd0);
		dir_in[21] = make_word(KIND_TICK, 32'd5, 8'd0, OUT_SENT, 1'b1, QT_PING, 16'd0);
		dir_in[22] = make_word(KIND_TICK, 32'd6, 8'd1, OUT_SENT, 1'b1, QT_PING, 16'd0);

		// reset once
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		cfg_check();

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == ZERO_CFG_ROW) begin
				settle();
				for (int r = REG_PING_IVL; r <= REG_BACKLOG_LIM; r++)
					apb_write(r[2:0], 32'd0);
				n_settings++;
			end
			send_word(dir_in[i], dir_known[i], dir_res[i]);
		end
		clock_ms = 32'd6;

		// random phases over several settings, extremes included
		run_phase(RST_PING_IVL, RST_POS_IVL, RST_STATUS_IVL, RST_POD_IVL, RST_MIDI_IVL,
			RST_TIMEOUT, RST_BACKLOG_LIM, 60, 120, 1'b0);
		run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 3, 100, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
			30000, 120, 1'b0);
		run_phase(16'd100, 16'd50, 16'd200, 16'd10, 16'd5, 16'd1, 8'hFF, 40, 130, 1'b1);
		run_phase(16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
			16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
			16'($urandom_range(0, 100)), 16'($urandom_range(0, 300)),
			8'($urandom_range(0, 255)), 50, 130, 1'b0);
		run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)), $urandom_range(1, 70000), 130, 1'b0);
		run_phase(16'd7, 16'hFFFF, 16'd0, 16'd3, 16'd1, 16'hFFFF, 8'd0, 20, 110, 1'b0);

		settle();
		$display("covered %0d words under %0d register settings", n_words, n_settings);
		$display("seen %0d queries sent, %0d expiries, %0d stale responses",
			n_sent_seen, n_expired_seen, n_stale);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/pqps_pkg.sv
hw/rtl/pqps_cfg.sv
hw/rtl/periodic_query_poll_scheduler_top.sv
sim/tb_periodic_query_poll_scheduler_top.sv
